[rtl/rpn_pkg.sv]
package rpn_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int FRAC_BITS   = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Request kinds
   localparam logic [3:0] KIND_PUSH    = 4'd0;
   localparam logic [3:0] KIND_ADD     = 4'd1;
   localparam logic [3:0] KIND_SUB     = 4'd2;
   localparam logic [3:0] KIND_MUL     = 4'd3;
   localparam logic [3:0] KIND_DIV     = 4'd4;
   localparam logic [3:0] KIND_REM     = 4'd5;
   localparam logic [3:0] KIND_PEEK    = 4'd6;
   localparam logic [3:0] KIND_DUP     = 4'd7;
   localparam logic [3:0] KIND_SWAP    = 4'd8;
   localparam logic [3:0] KIND_CLEAR   = 4'd9;
   localparam logic [3:0] KIND_POPSHOW = 4'd10;

   // Status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EMPTY   = 3'd1;
   localparam logic [2:0] ST_ONE     = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_ZDIV    = 3'd4;
   localparam logic [2:0] ST_UNKNOWN = 3'd5;

   typedef struct packed {
      logic [3:0]  kind;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic        shown;
      logic signed [31:0] shown_value;
      logic [2:0]  status;
   } rsp_type;

   // Divider control between sequencer and unit
   typedef struct packed {
      logic start;
      logic is_rem;
   } div_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = 32'sh7fffffff;
      else if (v < -66'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

[rtl/rpn_if.sv]
interface rpn_req_if;
   import rpn_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rpn_rsp_if;
   import rpn_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/rpn_ram.sv]
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/rpn_div.sv]
// Restoring divider, one quotient bit per cycle on magnitudes.
// Divide: (a << FRAC_BITS) / b saturated. Remainder: a % b, sign of a.
module rpn_div
   import rpn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic               done,
   output logic signed [31:0] result
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int SW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;   // shifts out dividend, shifts in quotient
   logic [32:0]   rem_ff, rem_in;
   logic [31:0]   den_ff, den_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, rem_op_ff, rem_op_in;
   logic [32:0]   trial;
   logic [33:0]   diff;
   logic [31:0]   amag, bmag;
   logic signed [65:0] qs;

   assign amag = a[31] ? 32'(-a) : a;
   assign bmag = b[31] ? 32'(-b) : b;
   assign trial = {rem_ff[31:0], num_ff[NW-1]};
   assign diff  = {1'b0, trial} - {2'b0, den_ff};

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_q_in = neg_q_ff; neg_r_in = neg_r_ff;
      rem_op_in = rem_op_ff;
      if (ctl.start) begin
         num_in = ctl.is_rem ? NW'(amag) : (NW'(amag) << FRAC_BITS);
         if (ctl.is_rem) num_in = NW'(amag) << FRAC_BITS;
         rem_in = '0; den_in = bmag;
         cnt_in = ctl.is_rem ? SW'(32) : SW'(NW);
         busy_in = 1'b1;
         neg_q_in = a[31] ^ b[31];
         neg_r_in = a[31];
         rem_op_in = ctl.is_rem;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; rem_op_ff <= rem_op_in;
   end

   // done pulses the cycle after the last step
   logic busy_d_ff;
   always_ff @(posedge clock) begin
      if (reset) busy_d_ff <= 1'b0;
      else busy_d_ff <= busy_ff;
   end
   assign done = busy_d_ff && !busy_ff;

   // Remainder run uses 32 steps over the high word: the low bits of num hold quotient
   always_comb begin
      qs = neg_q_ff ? -$signed({18'b0, num_ff}) : $signed({18'b0, num_ff});
      if (rem_op_ff)
         result = neg_r_ff ? 32'(-rem_ff[31:0]) : rem_ff[31:0];
      else
         result = sat32(qs);
   end
endmodule

[rtl/rpn_stack_calculator.sv]
// RPN stack calculator, signed Q16.16.
// req channel: one request = kind (push/add/sub/mul/div/rem/peek/dup/swap/
//   clear/popshow/unknown) and a Q16.16 operand used by push.
// rsp channel: exactly one response per request: shown flag, shown value,
//   first status code met.
// One request is handled at a time; req.ready is high only when idle.
// Clear and unknown kinds pass from idle straight to the output state; divide
//   runs 48 quotient steps and remainder 32 steps in the one-bit-per-cycle
//   divider, and a zero divisor skips the divider.
// The stack lives in a RAM with a registered read port, so each pop costs a RAM read.
// Reset clears the stack count and the sequencer; the RAM is not cleared.
// A response holds in its output register while rsp.ready is low, and the
//   next request is not taken until it is delivered.
module rpn_stack_calculator
   import rpn_pkg::*;
(
   input logic clock,
   input logic reset,
   rpn_req_if.sink   req,
   rpn_rsp_if.source rsp
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RDB   = 4'd1;
   localparam logic [3:0] S_GETB  = 4'd2;
   localparam logic [3:0] S_GETA  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_DIVW  = 4'd5;
   localparam logic [3:0] S_WR    = 4'd6;
   localparam logic [3:0] S_SWP2  = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;
   localparam logic [3:0] S_PUSHC = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         kind_ff, kind_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, res_ff, res_in;
   logic [2:0]         st_ff, st_in;
   logic               shown_ff, shown_in;
   logic signed [31:0] sval_ff, sval_in;
   logic               vld_ff, vld_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               prev_getA_ff;

   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr, rd_addr;
   logic signed [31:0] wr_data, rd_data;
   div_ctl_type        dctl;
   logic               ddone;
   logic signed [31:0] dres;

   rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   rpn_div u_div (
      .clock, .reset, .ctl(dctl), .a(a_ff), .b(b_ff), .done(ddone), .result(dres)
   );

   assign req.ready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp.valid = vld_ff;
   assign rsp.payload.shown = shown_ff;
   assign rsp.payload.shown_value = sval_ff;
   assign rsp.payload.status = st_ff;

   function automatic logic [2:0] note(input logic [2:0] s, input logic [2:0] c);
      return (s == ST_OK) ? c : s;
   endfunction

   logic signed [63:0] shr;
   assign shr = prod_ff >>> FRAC_BITS;

   // Sequencer
   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; kind_in = kind_ff;
      a_in = a_ff; b_in = b_ff; res_in = res_ff; st_in = st_ff;
      shown_in = shown_ff; sval_in = sval_ff; vld_in = vld_ff;
      prod_in = prod_ff;
      wr_en = 1'b0; wr_addr = cnt_ff[PTR_W-1:0]; wr_data = res_ff;
      rd_addr = PTR_W'(cnt_ff - 1'b1);
      dctl = '0;
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               kind_in = req.payload.kind; st_in = ST_OK; shown_in = 1'b0;
               sval_in = '0; res_in = req.payload.operand;
               a_in = '0; b_in = '0;
               priority if (req.payload.kind == KIND_PUSH) state_in = S_PUSHC;
               else if (req.payload.kind == KIND_CLEAR) begin
                  cnt_in = '0; state_in = S_OUT;
               end else if (req.payload.kind > KIND_POPSHOW) begin
                  st_in = ST_UNKNOWN; state_in = S_OUT;
               end else state_in = S_RDB;
            end
         end
         S_PUSHC: begin
            if (cnt_ff < CNT_W'(STACK_DEPTH)) begin
               wr_en = 1'b1; cnt_in = cnt_ff + 1'b1;
            end else st_in = note(st_ff, ST_FULL);
            state_in = S_OUT;
         end
         S_RDB: begin
            // RAM read of top (address presented this cycle)
            if (cnt_ff == '0) begin
               if (kind_ff == KIND_SWAP || kind_ff == KIND_PEEK || kind_ff == KIND_DUP) begin
                  st_in = ST_EMPTY; state_in = S_OUT;
               end else begin
                  st_in = ST_EMPTY; b_in = '0;
                  if (kind_ff == KIND_POPSHOW) begin
                     shown_in = 1'b1; sval_in = '0; state_in = S_OUT;
                  end else state_in = S_GETB;
               end
            end else if (kind_ff == KIND_SWAP && cnt_ff == CNT_W'(1)) begin
               st_in = ST_ONE; state_in = S_OUT;
            end else state_in = S_GETB;
         end
         S_GETB: begin
            if (st_ff == ST_OK) b_in = rd_data;
            priority case (kind_ff)
               KIND_PEEK: begin
                  shown_in = 1'b1; sval_in = rd_data; state_in = S_OUT;
               end
               KIND_DUP: begin
                  res_in = rd_data; state_in = S_PUSHC;
               end
               KIND_POPSHOW: begin
                  shown_in = 1'b1; sval_in = rd_data; cnt_in = cnt_ff - 1'b1;
                  state_in = S_OUT;
               end
               KIND_SWAP: begin
                  rd_addr = PTR_W'(cnt_ff - CNT_W'(2));
                  state_in = S_SWP2;
               end
               default: begin
                  if (st_ff == ST_OK) cnt_in = cnt_ff - 1'b1;
                  rd_addr = PTR_W'(cnt_ff - CNT_W'(2));
                  if ((kind_ff == KIND_DIV || kind_ff == KIND_REM)
                      && (st_ff != ST_OK || rd_data == '0)) begin
                     st_in = note(st_ff, ST_ZDIV); state_in = S_OUT;
                  end else state_in = S_GETA;
               end
            endcase
         end
         S_GETA: begin
            if (cnt_ff == '0) begin
               st_in = note(st_ff, ST_EMPTY); a_in = '0;
            end else begin
               a_in = rd_data; cnt_in = cnt_ff - 1'b1;
            end
            priority case (kind_ff)
               KIND_ADD: begin
                  res_in = sat32(66'(cnt_ff == '0 ? 32'sd0 : rd_data) + 66'(b_ff));
                  state_in = S_PUSHC;
               end
               KIND_SUB: begin
                  res_in = sat32(66'(cnt_ff == '0 ? 32'sd0 : rd_data) - 66'(b_ff));
                  state_in = S_PUSHC;
               end
               KIND_MUL: state_in = S_MUL;
               default: state_in = S_DIVW;
            endcase
         end
         S_MUL: begin
            prod_in = a_ff * b_ff;
            state_in = S_WR;
         end
         S_WR: begin
            res_in = sat32(66'(shr));
            state_in = S_PUSHC;
         end
         S_DIVW: begin
            if (ddone) begin
               res_in = dres; state_in = S_PUSHC;
            end
         end
         S_SWP2: begin
            // rd_data = second; b_ff = top
            wr_en = 1'b1; wr_addr = PTR_W'(cnt_ff - CNT_W'(2)); wr_data = b_ff;
            res_in = rd_data; cnt_in = cnt_ff - 1'b1;
            state_in = S_PUSHC;
         end
         S_OUT: begin
            vld_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // launch divider in the first S_DIVW cycle, once the operands are registered
      if (state_ff == S_DIVW && prev_getA_ff) begin
         dctl.start = 1'b1; dctl.is_rem = (kind_ff == KIND_REM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) prev_getA_ff <= 1'b0;
      else prev_getA_ff <= (state_ff == S_GETA);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
      kind_ff <= kind_in; a_ff <= a_in; b_ff <= b_in; res_ff <= res_in;
      st_ff <= st_in; shown_ff <= shown_in; sval_ff <= sval_in; prod_ff <= prod_in;
   end

   // Checks
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH)) else $error("stack count over depth");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !rsp.ready |=> vld_ff && $stable(sval_ff)) else $error("response lost");
   a_noacc: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
   a_shown: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !shown_ff |-> sval_ff == '0) else $error("value without show");
endmodule
